[sv/mme_pkg.sv]
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, types and helpers for the matrix multiply engine.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM = 16;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int SIZE_W  = 5;
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 36;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_C  = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_OF_B  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_OF_C  = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_DIM);

  typedef struct packed {
    logic              wr_b;
    logic              wr_c;
    logic [ADDR_W-1:0] wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              rd;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [ADDR_W-1:0] rd_addr_c;
    logic              clear;
  } mme_ctl_t;

  function automatic logic [SIZE_W-1:0] size_in_use(input logic [SIZE_W-1:0] r);
    return (r > SIZE_MAX) ? SIZE_MAX : r;
  endfunction

endpackage

[sv/mme_dot.sv]
// ----------------------------------------------------------------------------
// mme_dot
// B and C stores with a pipelined multiply-accumulate unit.
// ----------------------------------------------------------------------------
module mme_dot
  import mme_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mme_ctl_t                ctl,
  output logic signed [SUM_W-1:0] acc,
  output logic                    busy
);

  logic [VAL_W-1:0] b_store [DEPTH];
  logic [VAL_W-1:0] c_store [DEPTH];

  logic signed [VAL_W-1:0]  b_q;
  logic signed [VAL_W-1:0]  c_q;
  logic signed [PROD_W-1:0] prod;
  logic                     rd_vld;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    if (ctl.wr_b) begin
      b_store[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.wr_c) begin
      c_store[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd) begin
      b_q <= b_store[ctl.rd_addr_b];
      c_q <= c_store[ctl.rd_addr_c];
    end
    prod <= b_q * c_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
      acc      <= '0;
    end else begin
      rd_vld   <= ctl.rd;
      prod_vld <= rd_vld;
      if (ctl.clear) begin
        acc <= '0;
      end else if (prod_vld) begin
        acc <= acc + SUM_W'(prod);
      end
    end
  end

  assign busy = rd_vld | prod_vld;

endmodule

[sv/matrix_multiply_engine_top.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// Dense matrix product engine: loads B and C entries, computes A entries.
// ----------------------------------------------------------------------------
// Load transactions return nothing. A compute transaction streams row i of B
// and column j of C through a single 16x16 multiplier and a 36-bit
// accumulator, one inner index per cycle, and occupies the block from its
// acceptance to the next one through accept, store reads, multiply,
// accumulate, drain check and output load; an index error or an inner size
// of zero goes from accept straight to the output load. The result sits in an
// output register, so the next transaction can be taken while it waits.
// Entries never loaded read as unknown.
module matrix_multiply_engine_top
  import mme_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [SIZE_W-1:0]       cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         operation,
  input  logic [IDX_W-1:0]        row_index,
  input  logic [IDX_W-1:0]        col_index,
  input  logic signed [VAL_W-1:0] entry_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] product_sum,
  output logic                    index_error
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state;
  logic [SIZE_W-1:0] rows_of_b;
  logic [SIZE_W-1:0] inner_size;
  logic [SIZE_W-1:0] cols_of_c;
  logic [SIZE_W-1:0] k;
  logic [IDX_W-1:0]  row_q;
  logic [IDX_W-1:0]  col_q;
  logic              err_q;

  logic [SIZE_W-1:0] nr;
  logic [SIZE_W-1:0] nk;
  logic [SIZE_W-1:0] nc;
  logic              accept;
  logic              row_ok_b;
  logic              row_ok_k;
  logic              col_ok_k;
  logic              col_ok_c;
  logic              out_free;

  mme_ctl_t                ctl;
  logic signed [SUM_W-1:0] acc;
  logic                    busy;

  assign nr = size_in_use(rows_of_b);
  assign nk = size_in_use(inner_size);
  assign nc = size_in_use(cols_of_c);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  assign row_ok_b = SIZE_W'(row_index) < nr;
  assign row_ok_k = SIZE_W'(row_index) < nk;
  assign col_ok_k = SIZE_W'(col_index) < nk;
  assign col_ok_c = SIZE_W'(col_index) < nc;

  always_comb begin
    ctl           = '0;
    ctl.wr_addr   = {row_index, col_index};
    ctl.wr_data   = entry_value;
    ctl.wr_b      = accept & (operation == OP_LOAD_B) & row_ok_b & col_ok_k;
    ctl.wr_c      = accept & (operation == OP_LOAD_C) & row_ok_k & col_ok_c;
    ctl.clear     = accept & (operation == OP_COMPUTE);
    ctl.rd        = (state == S_RUN) & (k < nk);
    ctl.rd_addr_b = {row_q, k[IDX_W-1:0]};
    ctl.rd_addr_c = {k[IDX_W-1:0], col_q};
  end

  mme_dot u_dot (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .acc  (acc),
    .busy (busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_of_b  <= SIZE_MAX;
      inner_size <= SIZE_MAX;
      cols_of_c  <= SIZE_MAX;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROWS_OF_B:  rows_of_b  <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_COLS_OF_C:  cols_of_c  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= '0;
      err_q     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid & out_ready & (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && operation == OP_COMPUTE) begin
            row_q <= row_index;
            col_q <= col_index;
            err_q <= ~(row_ok_b & col_ok_c);
            k     <= '0;
            if (~(row_ok_b & col_ok_c) || nk == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (k < nk) begin
            k <= k + 1'b1;
          end else if (!busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_row     <= row_q;
            out_col     <= col_q;
            index_error <= err_q;
            product_sum <= err_q ? '0 : acc;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end else if (out_valid & out_ready) begin
            out_valid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
